// File: design/tes_pkg.sv
// Shared types, widths and codes for the triangle edge stepper.
`default_nettype none

package tes_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int ROW_W     = 16;
    localparam int DIFF_W    = DATA_W + 1;
    localparam int NUM_W     = DIFF_W + FRAC_W;
    localparam int PROD_W    = DATA_W + FRAC_W;
    localparam int CFG_NUM   = 6;
    localparam int CFG_IDX_W = 3;
    localparam int N_INTERP  = 3;
    localparam int CHAN_W    = 2;
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    typedef enum logic {
        CMD_SETUP = 1'b0,
        CMD_STEP  = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SLOPE,
        ST_MUL,
        ST_ACC
    } t_state;

    typedef enum logic [1:0] {
        PH_X,
        PH_GX_XERR,
        PH_GY_YERR,
        PH_GX_SLOPE
    } t_phase;

    typedef struct packed {
        logic                     cmd;
        logic signed [DATA_W-1:0] top_x;
        logic signed [DATA_W-1:0] top_y;
        logic signed [DATA_W-1:0] bottom_x;
        logic signed [DATA_W-1:0] bottom_y;
        logic signed [DATA_W-1:0] top_u_over_z;
        logic signed [DATA_W-1:0] top_v_over_z;
        logic signed [DATA_W-1:0] top_inv_depth;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] edge_x;
        logic signed [DATA_W-1:0] u_over_z;
        logic signed [DATA_W-1:0] v_over_z;
        logic signed [DATA_W-1:0] inv_depth;
        logic signed [ROW_W-1:0]  first_row;
        logic signed [ROW_W-1:0]  end_row;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]     idx;
        logic signed [DATA_W-1:0] data;
    } t_cfg_item;

endpackage

`default_nettype wire

// File: design/tes_if.sv
// Valid/ready channel interfaces for setup/step words, result words and register writes.
`default_nettype none

interface tes_in_if;
    logic                valid;
    logic                ready;
    tes_pkg::t_in_item   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tes_out_if;
    logic                valid;
    logic                ready;
    tes_pkg::t_out_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tes_cfg_if;
    logic                valid;
    logic                ready;
    tes_pkg::t_cfg_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/triangle_edge_stepper_top.sv
// Perspective-correct edge walker: setup with slope division, per-row stepping.
//
//   channel  dir  handshake          word
//   i_in     in   i_in.valid/ready   cmd, vertices, top interpolants
//   o_out    out  o_out.valid/ready  edge x, u/z, v/z, 1/z, first/end row
//   i_cfg    in   i_cfg.valid/ready  register index, 32-bit data
//
// A step word's result is in the output register the next cycle.
// A setup word runs the bit-serial slope divider, then saturates the quotient, then forms
// 10 products on the one 32x32 multiplier, each in a multiply and an accumulate state.
// i_in.ready is low during setup and while an untaken result sits in the output register.
// Reset clears the gradient registers, the edge state and the control; no clearing pass.
`default_nettype none

module triangle_edge_stepper_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tes_in_if.sink           i_in,
    tes_out_if.source        o_out,
    tes_cfg_if.sink          i_cfg
);

    localparam int DW = tes_pkg::DATA_W;
    localparam int FW = tes_pkg::FRAC_W;
    localparam int NW = tes_pkg::NUM_W;
    localparam int XW = tes_pkg::DIFF_W;
    localparam int PW = tes_pkg::PROD_W;
    localparam int NI = tes_pkg::N_INTERP;
    localparam int CW = tes_pkg::CHAN_W;

    // control
    tes_pkg::t_state            r_state, n_state;
    tes_pkg::t_phase            r_phase, n_phase;
    logic [CW-1:0]              r_chan, n_chan;
    logic [tes_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_out_valid;

    // configuration and edge state
    logic signed [DW-1:0]       r_cfg [tes_pkg::CFG_NUM];
    logic signed [DW-1:0]       r_cur_x, r_x_step;
    logic signed [DW-1:0]       r_cur_c  [NI];
    logic signed [DW-1:0]       r_step_c [NI];
    logic signed [tes_pkg::ROW_W-1:0] r_row_first, r_row_end;
    logic signed [DW-1:0]       r_slope;

    // setup working registers
    logic [NW-1:0]              r_num;
    logic [XW-1:0]              r_den;
    logic [XW-1:0]              r_rem;
    logic                       r_neg;
    logic signed [DW-1:0]       r_tx;
    logic signed [DW-1:0]       r_top [NI];
    logic [FW-1:0]              r_yerr;
    logic signed [DW-1:0]       r_xerr;
    logic [PW-1:0]              r_prod;
    logic [PW-1:0]              r_acc;

    logic in_acc, out_take, cfg_acc, in_setup, in_step, last_op;
    assign in_acc   = i_in.valid && i_in.ready;
    assign out_take = o_out.valid && o_out.ready;
    assign cfg_acc  = i_cfg.valid && i_cfg.ready;
    assign in_setup = in_acc && (i_in.data.cmd == tes_pkg::CMD_SETUP);
    assign in_step  = in_acc && (i_in.data.cmd == tes_pkg::CMD_STEP);
    assign last_op  = (r_phase == tes_pkg::PH_GX_SLOPE) && (r_chan == CW'(NI - 1));

    // ---------------- setup word decode ----------------
    logic signed [XW-1:0] dx, dy;
    logic [XW-1:0]        dx_mag, dy_mag;
    logic [FW-1:0]        yerr_in;
    logic [FW-1:0]        yerr_bot;
    logic [DW-1:0]        top_ceil, bot_ceil;
    always_comb begin
        dx      = XW'(i_in.data.bottom_x) - XW'(i_in.data.top_x);
        dy      = XW'(i_in.data.bottom_y) - XW'(i_in.data.top_y);
        dx_mag  = dx[XW-1] ? XW'(-dx) : XW'(dx);
        dy_mag  = dy[XW-1] ? XW'(-dy) : XW'(dy);
        yerr_in = FW'(~i_in.data.top_y[FW-1:0]) + FW'(1);
        yerr_bot = FW'(~i_in.data.bottom_y[FW-1:0]) + FW'(1);
        top_ceil = DW'(i_in.data.top_y) + DW'(yerr_in);
        bot_ceil = DW'(i_in.data.bottom_y) + DW'(yerr_bot);
    end

    // ---------------- restoring divider step ----------------
    logic [XW:0]   rem_shift;
    logic          div_ge;
    logic [XW:0]   rem_diff;
    always_comb begin
        rem_shift = {r_rem, r_num[NW-1]};
        div_ge    = rem_shift >= {1'b0, r_den};
        rem_diff  = rem_shift - {1'b0, r_den};
    end

    // saturate and sign the quotient
    logic signed [DW-1:0] slope_fin;
    always_comb begin
        if (r_den == '0) begin
            slope_fin = '0;
        end else if (!r_neg) begin
            if (r_num[NW-1:DW-1] != '0) slope_fin = {1'b0, {(DW-1){1'b1}}};
            else                        slope_fin = DW'(r_num[DW-1:0]);
        end else begin
            if ((r_num[NW-1:DW] != '0) || (r_num[DW-1] && (r_num[DW-2:0] != '0)))
                slope_fin = {1'b1, {(DW-1){1'b0}}};
            else
                slope_fin = DW'(-r_num[DW-1:0]);
        end
    end

    // ---------------- shared multiplier ----------------
    logic [tes_pkg::CFG_IDX_W-1:0] cfg_addr;
    logic signed [DW-1:0]          cfg_rd;
    logic signed [DW-1:0]          mul_a, mul_b;
    logic signed [2*DW-1:0]        mul_full;
    logic                          in_ready;

    // sequencer outputs: handshake and operand selection
    always_comb begin
        in_ready = (r_state == tes_pkg::ST_IDLE) && (!r_out_valid || o_out.ready);
        if (r_state == tes_pkg::ST_ACC || r_phase == tes_pkg::PH_GY_YERR)
            cfg_addr = tes_pkg::CFG_IDX_W'({r_chan, 1'b1});
        else
            cfg_addr = tes_pkg::CFG_IDX_W'({r_chan, 1'b0});
        case (r_phase)
            tes_pkg::PH_X: begin
                mul_a = r_slope;
                mul_b = DW'(r_yerr);
            end
            tes_pkg::PH_GX_XERR: begin
                mul_a = cfg_rd;
                mul_b = r_xerr;
            end
            tes_pkg::PH_GY_YERR: begin
                mul_a = cfg_rd;
                mul_b = DW'(r_yerr);
            end
            default: begin
                mul_a = cfg_rd;
                mul_b = r_slope;
            end
        endcase
    end

    assign cfg_rd   = r_cfg[cfg_addr];
    assign mul_full = mul_a * mul_b;

    logic [PW-1:0] acc_sum;
    assign acc_sum = r_acc + r_prod;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_chan  = r_chan;
        case (r_state)
            tes_pkg::ST_IDLE: begin
                if (in_setup) n_state = tes_pkg::ST_DIV;
            end
            tes_pkg::ST_DIV: begin
                if (r_cnt == tes_pkg::CNT_W'(tes_pkg::DIV_STEPS - 1))
                    n_state = tes_pkg::ST_SLOPE;
            end
            tes_pkg::ST_SLOPE: begin
                n_state = tes_pkg::ST_MUL;
                n_phase = tes_pkg::PH_X;
                n_chan  = '0;
            end
            tes_pkg::ST_MUL: begin
                n_state = tes_pkg::ST_ACC;
            end
            tes_pkg::ST_ACC: begin
                n_state = last_op ? tes_pkg::ST_IDLE : tes_pkg::ST_MUL;
                case (r_phase)
                    tes_pkg::PH_X:       n_phase = tes_pkg::PH_GX_XERR;
                    tes_pkg::PH_GX_XERR: n_phase = tes_pkg::PH_GY_YERR;
                    tes_pkg::PH_GY_YERR: n_phase = tes_pkg::PH_GX_SLOPE;
                    default: begin
                        n_phase = tes_pkg::PH_GX_XERR;
                        n_chan  = r_chan + CW'(1);
                    end
                endcase
            end
            default: n_state = tes_pkg::ST_IDLE;
        endcase
    end

    // ---------------- control and state registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tes_pkg::ST_IDLE;
            r_phase     <= tes_pkg::PH_X;
            r_chan      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_cur_x     <= '0;
            r_x_step    <= '0;
            r_row_first <= '0;
            r_row_end   <= '0;
            for (int i = 0; i < tes_pkg::CFG_NUM; i++) r_cfg[i] <= '0;
            for (int i = 0; i < NI; i++) begin
                r_cur_c[i]  <= '0;
                r_step_c[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_chan  <= n_chan;

            if (cfg_acc && (i_cfg.data.idx < tes_pkg::CFG_IDX_W'(tes_pkg::CFG_NUM)))
                r_cfg[i_cfg.data.idx] <= i_cfg.data.data;

            if (in_setup)                       r_cnt <= '0;
            else if (r_state == tes_pkg::ST_DIV) r_cnt <= r_cnt + tes_pkg::CNT_W'(1);

            if (in_step || (r_state == tes_pkg::ST_ACC && last_op))
                r_out_valid <= 1'b1;
            else if (out_take)
                r_out_valid <= 1'b0;

            // advance the edge x and every interpolant by its increment
            if (in_step) begin
                r_cur_x <= r_cur_x + r_x_step;
                for (int i = 0; i < NI; i++) r_cur_c[i] <= r_cur_c[i] + r_step_c[i];
            end

            if (in_setup) begin
                r_row_first <= tes_pkg::ROW_W'(top_ceil[DW-1:FW]);
                r_row_end   <= tes_pkg::ROW_W'(bot_ceil[DW-1:FW]);
            end

            if (r_state == tes_pkg::ST_SLOPE) r_x_step <= slope_fin;

            if (r_state == tes_pkg::ST_ACC) begin
                case (r_phase)
                    tes_pkg::PH_X:
                        r_cur_x <= r_tx + DW'(r_prod[PW-1:FW]);
                    tes_pkg::PH_GX_XERR: ;
                    tes_pkg::PH_GY_YERR:
                        r_cur_c[r_chan] <= r_top[r_chan] + DW'(acc_sum[PW-1:FW]);
                    default:
                        r_step_c[r_chan] <= cfg_rd + DW'(r_prod[PW-1:FW]);
                endcase
            end
        end
    end

    // ---------------- working registers ----------------
    always_ff @(posedge i_clk) begin
        if (in_setup) begin
            r_num    <= {dx_mag, {FW{1'b0}}};
            r_den    <= dy_mag;
            r_rem    <= '0;
            r_neg    <= dx[XW-1] ^ dy[XW-1];
            r_tx     <= i_in.data.top_x;
            r_yerr   <= yerr_in;
            r_top[0] <= i_in.data.top_u_over_z;
            r_top[1] <= i_in.data.top_v_over_z;
            r_top[2] <= i_in.data.top_inv_depth;
        end
        if (r_state == tes_pkg::ST_DIV) begin
            r_rem <= div_ge ? rem_diff[XW-1:0] : rem_shift[XW-1:0];
            r_num <= {r_num[NW-2:0], div_ge};
        end
        if (r_state == tes_pkg::ST_SLOPE) r_slope <= slope_fin;
        if (r_state == tes_pkg::ST_MUL)   r_prod  <= mul_full[PW-1:0];
        if (r_state == tes_pkg::ST_ACC) begin
            if (r_phase == tes_pkg::PH_X)       r_xerr <= DW'(r_prod[PW-1:FW]);
            if (r_phase == tes_pkg::PH_GX_XERR) r_acc  <= r_prod;
        end
    end

    // ---------------- ports ----------------
    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    always_comb begin
        o_out.data.edge_x    = r_cur_x;
        o_out.data.u_over_z  = r_cur_c[0];
        o_out.data.v_over_z  = r_cur_c[1];
        o_out.data.inv_depth = r_cur_c[2];
        o_out.data.first_row = r_row_first;
        o_out.data.end_row   = r_row_end;
    end

    // ---------------- assertions ----------------
    a_setup_hides_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_setup |=> !r_out_valid)
        else $error("result shown while setup is running");

    a_step_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_step |=> r_out_valid)
        else $error("step result missing the cycle after the step word");

    a_flat_edge_slope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tes_pkg::ST_SLOPE && r_den == '0) |=> (r_x_step == '0))
        else $error("horizontal edge got a nonzero slope");

    a_no_accept_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("word accepted while result is stalled");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != tes_pkg::ST_IDLE) |-> (!i_in.ready && !r_out_valid))
        else $error("ready or result valid during setup");

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the triangle edge stepper: predicted setup and row steps.
`timescale 1ns / 1ps

module tb_top;
    import tes_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 80;
    localparam int RANDOM_WORDS = 720;
    localparam int PHASES       = 6;

    localparam logic signed [DATA_W-1:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7FFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_U_DX,
        REG_U_DY,
        REG_V_DX,
        REG_V_DY,
        REG_W_DX,
        REG_W_DY
    } t_grad_reg;

    logic i_clk;
    logic i_rst_n;

    tes_in_if  in_ch ();
    tes_out_if out_ch ();
    tes_cfg_if cfg_ch ();

    triangle_edge_stepper_top dut (
        .i_clk,
        .i_rst_n,
        .i_in  (in_ch),
        .o_out (out_ch),
        .i_cfg (cfg_ch)
    );

    // Gradient registers and edge state as the block should hold them
    logic signed [DATA_W-1:0] grad [CFG_NUM];
    logic [DATA_W-1:0] x_pos = '0, x_inc = '0;
    logic [DATA_W-1:0] u_pos = '0, u_inc = '0;
    logic [DATA_W-1:0] v_pos = '0, v_inc = '0;
    logic [DATA_W-1:0] w_pos = '0, w_inc = '0;
    logic [ROW_W-1:0]  row_top = '0, row_bot = '0;

    t_out_item pending_edges [$];

    int mismatch_cnt = 0;
    int checked_cnt  = 0;
    int setup_cnt    = 0;
    int step_cnt     = 0;
    int write_cnt    = 0;
    int quiet_cycles = 0;
    int sink_hold    = 0;
    bit steady       = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int idle_len();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Distance from y up to the next whole row, Q16.16
    function automatic longint ceil_gap(input longint y);
        logic [FRAC_W-1:0] frac;
        frac = y[FRAC_W-1:0];
        return (frac == '0) ? 64'sd0 : 64'sd65536 - longint'(frac);
    endfunction

    function automatic void interp_setup(input longint top, input longint gx,
                                         input longint gy, input longint xerr,
                                         input longint yerr, input longint slope,
                                         output logic [DATA_W-1:0] pos,
                                         output logic [DATA_W-1:0] inc);
        pos = 32'(top + ((gx * xerr + gy * yerr) >>> 16));
        inc = 32'(gy + ((gx * slope) >>> 16));
    endfunction

    // Apply one word to the edge state and return the word the block should emit
    function automatic t_out_item advance_edge(input t_in_item w);
        longint tx, ty, bx, by, dy, slope, yerr, xerr;
        t_out_item r;
        if (w.cmd == CMD_SETUP) begin
            tx = $signed(w.top_x);
            ty = $signed(w.top_y);
            bx = $signed(w.bottom_x);
            by = $signed(w.bottom_y);
            dy = by - ty;
            slope = 0;
            if (dy != 0) begin
                slope = ((bx - tx) * 64'sd65536) / dy;
                if (slope > longint'(S_MAX))
                    slope = S_MAX;
                if (slope < longint'(S_MIN))
                    slope = S_MIN;
            end
            yerr    = ceil_gap(ty);
            xerr    = (slope * yerr) >>> 16;
            row_top = 16'((ty + yerr) >>> 16);
            row_bot = 16'((by + ceil_gap(by)) >>> 16);
            x_inc   = 32'(slope);
            x_pos   = 32'(tx + xerr);
            interp_setup($signed(w.top_u_over_z), grad[REG_U_DX], grad[REG_U_DY],
                         xerr, yerr, slope, u_pos, u_inc);
            interp_setup($signed(w.top_v_over_z), grad[REG_V_DX], grad[REG_V_DY],
                         xerr, yerr, slope, v_pos, v_inc);
            interp_setup($signed(w.top_inv_depth), grad[REG_W_DX], grad[REG_W_DY],
                         xerr, yerr, slope, w_pos, w_inc);
            setup_cnt++;
        end else begin
            x_pos = x_pos + x_inc;
            u_pos = u_pos + u_inc;
            v_pos = v_pos + v_inc;
            w_pos = w_pos + w_inc;
            step_cnt++;
        end
        r.edge_x    = x_pos;
        r.u_over_z  = u_pos;
        r.v_over_z  = v_pos;
        r.inv_depth = w_pos;
        r.first_row = row_top;
        r.end_row   = row_bot;
        return r;
    endfunction

    function automatic void note_field(input string name, input logic [DATA_W-1:0] want,
                                       input logic [DATA_W-1:0] got);
        if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
        end
    endfunction

    // Result side: random backpressure
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            out_ch.ready = 1'b0;
            sink_hold--;
        end else begin
            out_ch.ready = 1'b1;
            sink_hold = idle_len();
        end
    end

    always @(posedge i_clk) begin
        t_out_item want, got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (pending_edges.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("%0t: result word with nothing expected: %h", $time, got);
            end else begin
                want = pending_edges.pop_front();
                note_field("edge_x", want.edge_x, got.edge_x);
                note_field("u_over_z", want.u_over_z, got.u_over_z);
                note_field("v_over_z", want.v_over_z, got.v_over_z);
                note_field("inv_depth", want.inv_depth, got.inv_depth);
                note_field("first_row", want.first_row, got.first_row);
                note_field("end_row", want.end_row, got.end_row);
                checked_cnt++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Send one word; valid stays high after acceptance until the next word or a settle
    task automatic push_word(input t_in_item w);
        int gap;
        gap = idle_len();
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.data  = w;
        in_ch.valid = 1'b1;
        forever begin
            @(posedge i_clk);
            if (in_ch.ready)
                break;
        end
        pending_edges.push_back(advance_edge(w));
    endtask

    task automatic settle();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending_edges.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input t_grad_reg r, input logic signed [DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.data.idx  = r;
        cfg_ch.data.data = val;
        cfg_ch.valid     = 1'b1;
        forever begin
            @(posedge i_clk);
            if (cfg_ch.ready)
                break;
        end
        grad[r] = val;
        write_cnt++;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic write_grads(input logic signed [DATA_W-1:0] ux, input logic signed [DATA_W-1:0] uy,
                               input logic signed [DATA_W-1:0] vx, input logic signed [DATA_W-1:0] vy,
                               input logic signed [DATA_W-1:0] wx, input logic signed [DATA_W-1:0] wy);
        write_reg(REG_U_DX, ux);
        write_reg(REG_U_DY, uy);
        write_reg(REG_V_DX, vx);
        write_reg(REG_V_DY, vy);
        write_reg(REG_W_DX, wx);
        write_reg(REG_W_DY, wy);
    endtask

    function automatic t_in_item edge_word(input logic signed [DATA_W-1:0] tx,
                                           input logic signed [DATA_W-1:0] ty,
                                           input logic signed [DATA_W-1:0] bx,
                                           input logic signed [DATA_W-1:0] by,
                                           input logic signed [DATA_W-1:0] u,
                                           input logic signed [DATA_W-1:0] v,
                                           input logic signed [DATA_W-1:0] w);
        t_in_item r;
        r.cmd           = CMD_SETUP;
        r.top_x         = tx;
        r.top_y         = ty;
        r.bottom_x      = bx;
        r.bottom_y      = by;
        r.top_u_over_z  = u;
        r.top_v_over_z  = v;
        r.top_inv_depth = w;
        return r;
    endfunction

    // Step and noise words carry random payload; a step must ignore it
    function automatic t_in_item noise_word(input bit any_cmd);
        t_in_item r;
        r = edge_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        r.cmd = any_cmd ? t_cmd'($urandom_range(0, 1)) : CMD_STEP;
        return r;
    endfunction

    function automatic t_in_item random_edge();
        logic signed [DATA_W-1:0] tx, ty, h, span;
        int pick;
        pick = $urandom_range(0, 19);
        ty   = $signed($urandom_range(0, 32'd131072000)) - 32'sd65536000;
        tx   = $signed($urandom_range(0, 32'd268435456)) - 32'sd134217728;
        span = $signed($urandom_range(0, 32'd67108864)) - 32'sd33554432;
        h    = $urandom_range(0, 32'd4194304);
        if (pick == 0) begin
            h = '0;
        end else if (pick == 1) begin
            h = -h;
        end else if (pick == 2) begin
            ty = $urandom;
            tx = $urandom;
        end else if (pick == 3) begin
            // nearly flat: slope runs into saturation
            h = $urandom_range(1, 255);
        end
        return edge_word(tx, ty, tx + span, ty + h, $urandom, $urandom, $urandom);
    endfunction

    function automatic logic signed [DATA_W-1:0] grad_pick();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return S_MIN;
        if (r == 1)
            return S_MAX;
        if (r == 2)
            return '0;
        if (r == 3)
            return $signed($urandom_range(0, 32'd2097152)) - 32'sd1048576;
        return $urandom;
    endfunction

    task automatic test_step_before_setup();
        repeat (3) push_word(noise_word(1'b0));
        settle();
    endtask

    task automatic test_directed_edges();
        write_grads(S_MAX, S_MIN, 32'sh0123_4567, -32'sh00AB_CDEF, S_MIN, S_MAX);
        push_word(edge_word(32'sh000A_8000, 32'sh0003_4000, 32'sh0014_0000, 32'sh000D_C000,
                            32'sh1000_0000, -32'sh0800_0000, 32'sh0400_0000));
        push_word(noise_word(1'b0));
        push_word(noise_word(1'b0));
        // horizontal edge
        push_word(edge_word('0, 32'sh0005_8000, 32'sh0010_0000, 32'sh0005_8000,
                            32'sh0100_0000, 32'sh0200_0000, 32'sh0300_0000));
        // slope saturates both ways
        push_word(edge_word(S_MIN, '0, S_MAX, 32'sd1, S_MAX, S_MIN, 32'sh1234_5678));
        push_word(edge_word(S_MAX, '0, S_MIN, 32'sd1, S_MIN, S_MAX, -32'sh1234_5678));
        // bottom above top
        push_word(edge_word(32'sh0020_0000, 32'sh0030_8000, 32'sh0008_0000, 32'sh0010_4000,
                            32'sh0F00_0000, 32'sh0E00_0000, 32'sh0D00_0000));
        push_word(noise_word(1'b0));
        // ceiling of y past the last 16-bit row
        push_word(edge_word('0, 32'sh7FFF_0001, 32'sh0001_0000, S_MAX,
                            32'sh0000_1000, 32'sh0000_2000, 32'sh0000_3000));
        // y on a whole row
        push_word(edge_word(32'sh0003_0000, 32'sh0005_0000, 32'sh0007_8000, 32'sh0009_0000,
                            32'sh0800_0000, 32'sh0900_0000, 32'sh0A00_0000));
        push_word(edge_word(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN));
        push_word(edge_word(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX));
        push_word(edge_word(S_MAX, S_MIN, S_MIN, S_MAX, S_MIN, S_MAX, '0));
        // steep edge, then steps that wrap every sum
        push_word(edge_word('0, '0, S_MAX, 32'sh0000_8000, S_MAX, S_MAX, S_MIN));
        repeat (3) push_word(noise_word(1'b0));
        push_word(edge_word('0, '0, '0, '0, '0, '0, '0));
        settle();
    endtask

    task automatic test_gradient_extremes();
        write_grads(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN);
        push_word(random_edge());
        repeat (2) push_word(noise_word(1'b0));
        settle();
        write_grads(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX);
        push_word(random_edge());
        repeat (2) push_word(noise_word(1'b0));
        settle();
        write_grads('0, '0, '0, '0, '0, '0);
        push_word(random_edge());
        repeat (2) push_word(noise_word(1'b0));
        settle();
    endtask

    // Mostly setup followed by a run of rows; now and then a stray word
    task automatic test_random_edges();
        int sent, rows;
        for (int ph = 0; ph < PHASES; ph++) begin
            write_grads(grad_pick(), grad_pick(), grad_pick(), grad_pick(), grad_pick(),
                        grad_pick());
            sent = 0;
            while (sent < RANDOM_WORDS / PHASES) begin
                steady = ($urandom_range(0, 7) == 0);
                if ($urandom_range(0, 99) < 85) begin
                    rows = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 6)
                                                      : $urandom_range(7, 24);
                    push_word(random_edge());
                    repeat (rows) push_word(noise_word(1'b0));
                    sent += rows + 1;
                end else begin
                    push_word(noise_word(1'b1));
                    sent++;
                end
            end
            steady = 1'b0;
            settle();
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.data    = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        out_ch.ready  = 1'b0;
        foreach (grad[i])
            grad[i] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_step_before_setup();
        test_directed_edges();
        test_gradient_extremes();
        test_random_edges();

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d setup and %0d step words across %0d gradient writes,",
                 setup_cnt, step_cnt, write_cnt);
        $display("with random stalls on both sides; %0d result words checked, %0d mismatches.",
                 checked_cnt, mismatch_cnt);
        if (mismatch_cnt == 0 && pending_edges.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: triangle_edge_stepper_top.f
design/tes_pkg.sv
design/tes_if.sv
design/triangle_edge_stepper_top.sv
tb/sv/tb_top.sv
